// File: rtl/akm_pkg.sv
`default_nettype none
package akm_pkg;

	localparam int KEY_CODES_DEF     = 64;
	localparam int FRAME_ENTRIES_DEF = 32;
	localparam int MAX_RESULTS       = 64;
	localparam int CNT_W             = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] FN_SAMPLE = 2'd0;
	localparam logic [1:0] FN_EOF    = 2'd1;
	localparam logic [1:0] FN_SHUT   = 2'd2;
	localparam logic [1:0] FN_MAP    = 2'd3;

	localparam logic [1:0] REG_ON_THR    = 2'd0;
	localparam logic [1:0] REG_OFF_THR   = 2'd1;
	localparam logic [1:0] REG_FULL_RATE = 2'd2;

	localparam logic [12:0] ON_THR_RST    = 13'd1434;
	localparam logic [12:0] OFF_THR_RST   = 13'd819;
	localparam logic [7:0]  FULL_RATE_RST = 8'd25;

	localparam logic [7:0]  STATUS_ON   = 8'h90;
	localparam logic [7:0]  STATUS_OFF  = 8'h80;
	localparam logic [7:0]  NOTE_NONE   = 8'hFF;
	localparam logic [6:0]  VEL_NO_TIME = 7'd96;
	localparam logic [6:0]  VEL_MIN     = 7'd1;
	localparam logic [6:0]  VEL_MAX     = 7'd127;
	localparam logic [26:0] VEL_SCALE   = 27'd126000000;

	// white keys from note 36 on the letter and number rows
	function automatic logic [7:0] default_note(input logic [7:0] code);
		logic [7:0] n;
		begin
			case (code)
				8'h2C: n = 8'd36;
				8'h2D: n = 8'd38;
				8'h2E: n = 8'd40;
				8'h2F: n = 8'd41;
				8'h30: n = 8'd43;
				8'h31: n = 8'd45;
				8'h32: n = 8'd47;
				8'h1E: n = 8'd48;
				8'h1F: n = 8'd50;
				8'h20: n = 8'd52;
				8'h21: n = 8'd53;
				8'h22: n = 8'd55;
				8'h23: n = 8'd57;
				8'h24: n = 8'd59;
				8'h25: n = 8'd60;
				8'h26: n = 8'd62;
				8'h10: n = 8'd64;
				8'h11: n = 8'd65;
				8'h12: n = 8'd67;
				8'h13: n = 8'd69;
				8'h14: n = 8'd71;
				8'h15: n = 8'd72;
				8'h16: n = 8'd74;
				8'h17: n = 8'd76;
				8'h18: n = 8'd77;
				8'h19: n = 8'd79;
				8'h02: n = 8'd81;
				8'h03: n = 8'd83;
				8'h04: n = 8'd84;
				8'h05: n = 8'd86;
				8'h06: n = 8'd88;
				8'h07: n = 8'd89;
				8'h08: n = 8'd91;
				8'h09: n = 8'd93;
				8'h0A: n = 8'd95;
				8'h0B: n = 8'd96;
				default: n = NOTE_NONE;
			endcase
			return n;
		end
	endfunction

endpackage
`default_nettype wire

// File: rtl/analog_key_to_midi_notes.sv
// a key sample goes through the read, sample and flush states; when the velocity divider
//   runs, the multiply state and one saturation check and seven quotient bits, one a cycle,
//   come before the flush; end of frame and shutdown sweep the key memories through read
//   and evaluate states per key code; map writes finish in idle; one transaction at a time
// reset clears thresholds and rate to defaults, key state and frame count; the note map
//   reads its default layout until an entry is written
`default_nettype none
module analog_key_to_midi_notes import akm_pkg::*; #(
	parameter int KEY_CODES     = KEY_CODES_DEF,
	parameter int FRAME_ENTRIES = FRAME_ENTRIES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// key_code, key_depth, elapsed_us, stamp, map_note, zero pad
	input  wire logic [127:0] s_tdata,
	// func
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status_byte, note_number, velocity, out_stamp, zero pad
	output logic [87:0]       m_tdata,
	output logic              m_tlast,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int KW = $clog2(KEY_CODES);
	localparam int FW = $clog2(FRAME_ENTRIES + 1);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_RD    = 8'b0000_0010,
		ST_SAMP  = 8'b0000_0100,
		ST_MUL   = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_SWRD  = 8'b0010_0000,
		ST_SWEV  = 8'b0100_0000,
		ST_FLUSH = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [12:0] on_thr_q, off_thr_q;
	logic [7:0]  rate_q;

	logic [7:0]  note_mem [KEY_CODES];
	logic [12:0] depth_mem [KEY_CODES];
	logic [7:0]  note_rd_q;
	logic [12:0] depth_rd_q;

	logic [KEY_CODES-1:0] down_q, seen_q, depth_vld_q, note_wr_q;
	logic [FW-1:0]    fc_q;
	logic [CNT_W-1:0] cnt_q;

	logic [1:0]    op_q;
	logic [KW-1:0] code_q;
	logic [12:0]   depth_q, delta_q;
	logic [19:0]   us_q;
	logic [63:0]   stamp_q;

	logic        pend_vld_q;
	logic [7:0]  pend_status_q;
	logic [6:0]  pend_note_q, pend_vel_q;
	logic [63:0] pend_stamp_q;

	logic [47:0] rem_q, dsr_q;
	logic [2:0]  bit_q;
	logic [5:0]  quo_q;

	logic        m_tvalid_q, m_tlast_q;
	logic [87:0] m_tdata_q;

	logic [15:0] in_code;
	logic [12:0] in_depth;
	logic [19:0] in_us;
	logic [63:0] in_stamp;
	logic [7:0]  in_note;
	logic        in_acc, in_range, cfg_wr, out_free;
	logic [KW-1:0] rd_addr;
	logic [7:0]  note_eff;
	logic        mapped, down_k, seen_k, sw_msg, sw_take, sw_stall, ge;
	logic [12:0] prev;
	logic [6:0]  q_new;
	logic [39:0] num_w;
	logic [27:0] rate_us;

	assign in_code  = s_tdata[15:0];
	assign in_depth = s_tdata[28:16];
	assign in_us    = s_tdata[48:29];
	assign in_stamp = s_tdata[112:49];
	assign in_note  = s_tdata[120:113];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_range = (in_code < 16'(KEY_CODES));
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !m_tvalid_q || m_tready;
	assign pready   = 1'b1;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_comb begin
		case (paddr[3:2])
			REG_ON_THR:    prdata = {19'b0, on_thr_q};
			REG_OFF_THR:   prdata = {19'b0, off_thr_q};
			REG_FULL_RATE: prdata = {24'b0, rate_q};
			default:       prdata = 32'b0;
		endcase
	end

	assign rd_addr  = (state_q == ST_IDLE) ? in_code[KW-1:0] : code_q;
	assign note_eff = note_wr_q[code_q] ? note_rd_q : default_note(8'(code_q));
	assign mapped   = !note_eff[7];
	assign prev     = depth_vld_q[code_q] ? depth_rd_q : 13'b0;
	assign down_k   = down_q[code_q];
	assign seen_k   = seen_q[code_q];
	assign sw_msg   = (op_q == FN_EOF) ? (down_k && !seen_k && mapped) : (down_k && mapped);
	assign sw_take  = sw_msg && (cnt_q < CNT_W'(MAX_RESULTS));
	assign sw_stall = sw_take && pend_vld_q && !out_free;
	assign ge       = (rem_q >= dsr_q);
	assign q_new    = {quo_q, ge};
	assign num_w    = {27'b0, delta_q} * {13'b0, VEL_SCALE};
	assign rate_us  = {20'b0, rate_q} * {8'b0, us_q};

	// key memories, registered read
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == FN_MAP && in_range)
			note_mem[in_code[KW-1:0]] <= in_note[7] ? NOTE_NONE : in_note;
		if (state_q == ST_SAMP && mapped)
			depth_mem[code_q] <= depth_q;
		note_rd_q  <= note_mem[rd_addr];
		depth_rd_q <= depth_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			on_thr_q    <= ON_THR_RST;
			off_thr_q   <= OFF_THR_RST;
			rate_q      <= FULL_RATE_RST;
			down_q      <= '0;
			seen_q      <= '0;
			depth_vld_q <= '0;
			note_wr_q   <= '0;
			fc_q        <= '0;
			cnt_q       <= '0;
			pend_vld_q  <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_ON_THR:    on_thr_q  <= pwdata[12:0];
					REG_OFF_THR:   off_thr_q <= pwdata[12:0];
					REG_FULL_RATE: rate_q    <= pwdata[7:0];
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q     <= s_tuser;
						code_q   <= in_code[KW-1:0];
						depth_q  <= in_depth;
						us_q     <= in_us;
						stamp_q  <= in_stamp;
						cnt_q    <= '0;
						case (s_tuser)
							FN_SAMPLE: begin
								if (fc_q < FW'(FRAME_ENTRIES)) begin
									fc_q <= fc_q + FW'(1);
									if (in_range)
										state_q <= ST_RD;
								end
							end
							FN_EOF, FN_SHUT: begin
								code_q  <= '0;
								state_q <= ST_SWRD;
							end
							FN_MAP: begin
								if (in_range)
									note_wr_q[in_code[KW-1:0]] <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_RD: state_q <= ST_SAMP;
				ST_SAMP: begin
					state_q <= ST_FLUSH;
					if (mapped) begin
						seen_q[code_q]      <= 1'b1;
						depth_vld_q[code_q] <= 1'b1;
						pend_note_q  <= note_eff[6:0];
						pend_stamp_q <= stamp_q;
						if (!down_k && depth_q >= on_thr_q) begin
							down_q[code_q] <= 1'b1;
							pend_vld_q     <= 1'b1;
							pend_status_q  <= STATUS_ON;
							delta_q        <= depth_q - prev;
							if (us_q == 20'd0)
								pend_vel_q <= VEL_NO_TIME;
							else if (depth_q <= prev)
								pend_vel_q <= VEL_MIN;
							else if (rate_q == 8'd0)
								pend_vel_q <= VEL_MAX;
							else
								state_q <= ST_MUL;
						end else if (down_k && depth_q <= off_thr_q) begin
							down_q[code_q] <= 1'b0;
							pend_vld_q     <= 1'b1;
							pend_status_q  <= STATUS_OFF;
							pend_vel_q     <= 7'd0;
						end
					end
				end
				ST_MUL: begin
					rem_q   <= {8'b0, num_w};
					dsr_q   <= {1'b0, rate_us, 19'b0};
					bit_q   <= 3'd7;
					quo_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dsr_q <= dsr_q >> 1;
					if (bit_q == 3'd7) begin
						// quotient of 128 or more saturates
						if (ge) begin
							pend_vel_q <= VEL_MAX;
							state_q    <= ST_FLUSH;
						end
						bit_q <= bit_q - 3'd1;
					end else begin
						if (ge)
							rem_q <= rem_q - dsr_q;
						quo_q <= q_new[5:0];
						bit_q <= bit_q - 3'd1;
						if (bit_q == 3'd0) begin
							pend_vel_q <= (q_new == VEL_MAX) ? VEL_MAX : q_new + VEL_MIN;
							state_q    <= ST_FLUSH;
						end
					end
				end
				ST_SWRD: state_q <= ST_SWEV;
				ST_SWEV: begin
					if (!sw_stall) begin
						if (op_q == FN_EOF && down_k && !seen_k) begin
							down_q[code_q]      <= 1'b0;
							depth_vld_q[code_q] <= 1'b0;
						end
						if (sw_take) begin
							// hold one message back so the last can be marked
							if (pend_vld_q) begin
								m_tvalid_q <= 1'b1;
								m_tlast_q  <= 1'b0;
								m_tdata_q  <= {2'b0, pend_stamp_q, pend_vel_q, pend_note_q,
									pend_status_q};
							end
							pend_vld_q    <= 1'b1;
							pend_status_q <= STATUS_OFF;
							pend_note_q   <= note_eff[6:0];
							pend_vel_q    <= 7'd0;
							pend_stamp_q  <= (op_q == FN_EOF) ? stamp_q : 64'd0;
							cnt_q         <= cnt_q + CNT_W'(1);
						end
						if (code_q == KW'(KEY_CODES - 1)) begin
							state_q <= ST_FLUSH;
						end else begin
							code_q  <= code_q + KW'(1);
							state_q <= ST_SWRD;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_vld_q || out_free) begin
						if (pend_vld_q) begin
							m_tvalid_q <= 1'b1;
							m_tlast_q  <= 1'b1;
							m_tdata_q  <= {2'b0, pend_stamp_q, pend_vel_q, pend_note_q,
								pend_status_q};
						end
						pend_vld_q <= 1'b0;
						if (op_q == FN_EOF) begin
							seen_q <= '0;
							fc_q   <= '0;
						end else if (op_q == FN_SHUT) begin
							down_q      <= '0;
							seen_q      <= '0;
							depth_vld_q <= '0;
							fc_q        <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_vld_q) else $error("message pending while idle");
	a_div_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (pend_vld_q && dsr_q != 48'd0))
		else $error("divider running without message or divisor");
	a_frame_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FW'(FRAME_ENTRIES)) else $error("frame count overflow");
	a_msg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS)) else $error("message count overflow");
`endif

endmodule
`default_nettype wire

// File: sim/tb.sv
`default_nettype none
module tb;
	import akm_pkg::*;

	localparam int NKEYS      = 64;
	localparam int FRAME_MAX  = 32;
	localparam int CYCLE_CAP  = 2000000;
	localparam int SWEEP_WAIT = 2 * NKEYS + 20;

	typedef struct {
		logic [1:0]  func;
		logic [15:0] code;
		logic [12:0] depth;
		logic [19:0] us;
		logic [63:0] stamp;
		logic [7:0]  mnote;
	} key_item_t;

	typedef struct {
		logic [7:0]  status;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [63:0] stamp;
		logic        last;
	} midi_msg_t;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [87:0]  m_tdata;
	logic         m_tlast;
	logic         psel = 0;
	logic         penable = 0;
	logic         pwrite = 0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	analog_key_to_midi_notes dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// model state
	logic [12:0] on_thr, off_thr;
	logic [7:0]  rate;
	logic [7:0]  notes [NKEYS];
	logic        down [NKEYS];
	logic        seen [NKEYS];
	logic [12:0] depth_mem [NKEYS];
	int          frame_cnt;

	key_item_t  pending_items [$];
	midi_msg_t  expected_msgs [$];
	key_item_t  cur_item;
	int         errors = 0;
	int         gap = 0;
	int         rx_gap = 0;
	int         hold_cnt = 0;
	bit         hold_req = 0;
	int         cycles = 0;

	const logic [7:0] white_codes [36] = '{
		8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32,
		8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
		8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19,
		8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B
	};
	const int scale [7] = '{0, 2, 4, 5, 7, 9, 11};

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [6:0] strike_vel(logic [12:0] d, logic [12:0] p, logic [19:0] us);
		logic [63:0] num, den, q;
		if (us == 0) return VEL_NO_TIME;
		if (d <= p) return VEL_MIN;
		if (rate == 0) return VEL_MAX;
		num = 64'(d - p) * 64'd126000000;
		den = 64'd4096 * 64'(rate) * 64'(us);
		q = num / den;
		if (q > 126) q = 126;
		return 7'(q + 1);
	endfunction

	task automatic clear_keys();
		for (int k = 0; k < NKEYS; k++) begin
			down[k] = 0;
			seen[k] = 0;
			depth_mem[k] = 0;
		end
		frame_cnt = 0;
	endtask

	task automatic predict_notes(key_item_t it);
		midi_msg_t run [$];
		midi_msg_t m;
		logic [12:0] prev;
		int c;
		c = it.code;
		case (it.func)
			FN_SAMPLE: begin
				if (frame_cnt < FRAME_MAX) begin
					frame_cnt++;
					if (c < NKEYS && !notes[c][7]) begin
						prev = depth_mem[c];
						seen[c] = 1;
						depth_mem[c] = it.depth;
						m.note = notes[c][6:0];
						m.stamp = it.stamp;
						m.last = 0;
						if (!down[c] && it.depth >= on_thr) begin
							down[c] = 1;
							m.status = STATUS_ON;
							m.vel = strike_vel(it.depth, prev, it.us);
							run.push_back(m);
						end else if (down[c] && it.depth <= off_thr) begin
							down[c] = 0;
							m.status = STATUS_OFF;
							m.vel = 0;
							run.push_back(m);
						end
					end
				end
			end
			FN_EOF: begin
				for (int k = 0; k < NKEYS; k++) begin
					if (down[k] && !seen[k]) begin
						down[k] = 0;
						depth_mem[k] = 0;
						if (!notes[k][7] && run.size() < MAX_RESULTS) begin
							m = '{STATUS_OFF, notes[k][6:0], 7'd0, it.stamp, 1'b0};
							run.push_back(m);
						end
					end
				end
				for (int k = 0; k < NKEYS; k++) seen[k] = 0;
				frame_cnt = 0;
			end
			FN_SHUT: begin
				for (int k = 0; k < NKEYS; k++)
					if (down[k] && !notes[k][7] && run.size() < MAX_RESULTS) begin
						m = '{STATUS_OFF, notes[k][6:0], 7'd0, 64'd0, 1'b0};
						run.push_back(m);
					end
				clear_keys();
			end
			default: begin
				if (c < NKEYS) notes[c] = it.mnote[7] ? NOTE_NONE : it.mnote;
			end
		endcase
		if (run.size() > 0) run[run.size() - 1].last = 1;
		foreach (run[i]) expected_msgs.push_back(run[i]);
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) predict_notes(cur_item);
			if (!s_tvalid || s_tready) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 0;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					s_tvalid <= 1;
					s_tuser <= cur_item.func;
					s_tdata <= {7'd0, cur_item.mnote, cur_item.stamp, cur_item.us,
						cur_item.depth, cur_item.code};
					gap = pick_gap();
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		midi_msg_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_msgs.size() == 0) begin
					$error("unexpected transaction %h last %b", m_tdata, m_tlast);
					errors++;
				end else begin
					e = expected_msgs.pop_front();
					if (m_tdata[7:0] !== e.status) begin
						$error("status_byte exp %h got %h", e.status, m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[14:8] !== e.note) begin
						$error("note_number exp %0d got %0d", e.note, m_tdata[14:8]);
						errors++;
					end
					if (m_tdata[21:15] !== e.vel) begin
						$error("velocity exp %0d got %0d", e.vel, m_tdata[21:15]);
						errors++;
					end
					if (m_tdata[85:22] !== e.stamp) begin
						$error("out_stamp exp %h got %h", e.stamp, m_tdata[85:22]);
						errors++;
					end
					if (m_tlast !== e.last) begin
						$error("last_of_run exp %b got %b", e.last, m_tlast);
						errors++;
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 0;
			end else if (hold_req) begin
				hold_req = 0;
				hold_cnt = 400;
				m_tready <= 0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
				rx_gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_item(logic [1:0] f, logic [15:0] c, logic [12:0] d, logic [19:0] us,
		logic [63:0] st, logic [7:0] mn);
		key_item_t it;
		it = '{f, c, d, us, st, mn};
		pending_items.push_back(it);
	endtask

	task automatic wait_idle();
		wait (pending_items.size() == 0 && !s_tvalid && expected_msgs.size() == 0);
		repeat (SWEEP_WAIT) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_ON_THR:  on_thr = val[12:0];
			REG_OFF_THR: off_thr = val[12:0];
			default:     rate = val[7:0];
		endcase
	endtask

	function automatic logic [12:0] rand_depth();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 1) return 4096;
		return 13'($urandom_range(0, 4096));
	endfunction

	task automatic random_phase(int count);
		int n, len, r;
		logic [15:0] c;
		logic [19:0] us;
		logic [63:0] st;
		n = 0;
		while (n < count) begin
			r = $urandom_range(0, 99);
			st = {$urandom, $urandom};
			if (r < 5) begin
				add_item(FN_MAP, 16'($urandom_range(0, NKEYS - 1)), rand_depth(),
					20'($urandom), st, 8'($urandom_range(0, 128) - 1));
				n++;
			end else if (r < 8) begin
				add_item(FN_SHUT, 16'($urandom), rand_depth(), 20'($urandom), st, 8'($urandom));
				n++;
			end else begin
				len = $urandom_range(0, 38);
				us = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3000));
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(0, 99);
					if (r < 80) c = white_codes[$urandom_range(0, 35)];
					else if (r < 95) c = 16'($urandom_range(0, NKEYS - 1));
					else c = 16'($urandom);
					add_item(FN_SAMPLE, c, rand_depth(), us, st, 8'($urandom));
				end
				add_item(FN_EOF, 16'($urandom), rand_depth(), us, st, 8'($urandom));
				n += len + 1;
			end
		end
	endtask

	initial begin
		on_thr = ON_THR_RST;
		off_thr = OFF_THR_RST;
		rate = FULL_RATE_RST;
		for (int k = 0; k < NKEYS; k++) notes[k] = NOTE_NONE;
		for (int i = 0; i < 36; i++) notes[white_codes[i]] = 8'(36 + (i / 7) * 12 + scale[i % 7]);
		clear_keys();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: strikes at zero time, releases, unmapped and out-of-range codes, map edits
		add_item(FN_SAMPLE, 16'h002C, 13'd4096, 20'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		add_item(FN_SAMPLE, 16'h002D, 13'd4096, 20'hFFFFF, 64'd1, 8'h00);
		add_item(FN_SAMPLE, 16'h002E, 13'd2000, 20'd1, 64'd2, 8'h00);
		add_item(FN_SAMPLE, 16'h002C, 13'd0, 20'd10, 64'd3, 8'h00);
		add_item(FN_SAMPLE, 16'h0000, 13'd4096, 20'd10, 64'd4, 8'h00);
		add_item(FN_SAMPLE, 16'hFFFF, 13'd4096, 20'd10, 64'd5, 8'h00);
		add_item(FN_MAP, 16'h002D, 13'd0, 20'd0, 64'd6, 8'd0);
		add_item(FN_MAP, 16'hFFFF, 13'd0, 20'd0, 64'd7, 8'd5);
		add_item(FN_MAP, 16'h0000, 13'd0, 20'd0, 64'd8, 8'd127);
		add_item(FN_SAMPLE, 16'h0000, 13'd3000, 20'd500, 64'd9, 8'h00);
		add_item(FN_EOF, 16'h0000, 13'd0, 20'd0, 64'hA5A5_0000_FFFF_1234, 8'h00);
		add_item(FN_MAP, 16'h002F, 13'd0, 20'd0, 64'd11, 8'hFF);
		add_item(FN_SAMPLE, 16'h002F, 13'd4096, 20'd100, 64'd12, 8'h00);
		add_item(FN_SAMPLE, 16'h0030, 13'd4096, 20'd100, 64'd13, 8'h00);
		add_item(FN_SAMPLE, 16'h0031, 13'd1500, 20'd3, 64'd14, 8'h00);
		add_item(FN_MAP, 16'h0030, 13'd0, 20'd0, 64'd15, 8'hFF);
		add_item(FN_SHUT, 16'h0000, 13'd0, 20'd0, 64'd16, 8'h00);
		add_item(FN_MAP, 16'h0030, 13'd0, 20'd0, 64'd17, 8'd43);
		for (int i = 0; i < 34; i++)
			add_item(FN_SAMPLE, 16'(white_codes[i]), 13'd4096, 20'd50, 64'(100 + i), 8'h00);
		add_item(FN_EOF, 16'h0000, 13'd0, 20'd0, 64'd200, 8'h00);
		add_item(FN_EOF, 16'h0000, 13'd0, 20'd0, 64'd201, 8'h00);
		wait_idle();

		hold_req = 1;
		random_phase(60);
		wait_idle();
		reg_write(REG_ON_THR, 32'd4096);
		reg_write(REG_OFF_THR, 32'd0);
		reg_write(REG_FULL_RATE, 32'd255);
		random_phase(50);
		wait_idle();
		reg_write(REG_ON_THR, 32'd0);
		reg_write(REG_OFF_THR, 32'd4096);
		reg_write(REG_FULL_RATE, 32'd1);
		random_phase(40);
		wait_idle();
		reg_write(REG_ON_THR, 32'd2500);
		reg_write(REG_OFF_THR, 32'd1200);
		reg_write(REG_FULL_RATE, 32'd0);
		random_phase(35);
		wait_idle();
		reg_write(REG_ON_THR, ON_THR_RST);
		reg_write(REG_OFF_THR, OFF_THR_RST);
		reg_write(REG_FULL_RATE, FULL_RATE_RST);
		hold_req = 1;
		random_phase(25);
		add_item(FN_SHUT, 16'h0000, 13'd0, 20'd0, 64'd0, 8'h00);
		wait_idle();

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
